// ===== hdl/axis_vector_rotation_macros.svh =====
// assertion macros shared by the vector rotation block
`ifndef AXIS_VECTOR_ROTATION_MACROS_SVH
`define AXIS_VECTOR_ROTATION_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AVR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define AVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/avr_pkg.sv =====
// shared types, constants and the arctangent table for the vector rotation block
package avr_pkg;

  localparam int AVR_COORD_WIDTH   = 32;
  localparam int AVR_ANGLE_WIDTH   = 16;
  localparam int AVR_CORDIC_STAGES = 16;
  localparam int AVR_GUARD_BITS    = 12;
  localparam int AVR_Z_WIDTH       = 32;

  // inverse cordic gain, 0.60725293500888 in q0.32
  localparam logic [31:0] AVR_KINV_Q32 = 32'd2608131496;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } avr_axis_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } avr_quad_t;

  typedef struct packed {
    logic      vld;
    avr_axis_t mode;
  } avr_ctl_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] avr_atan_turn(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/avr_cordic_stage.sv =====
// one registered cordic micro-rotation stage
module avr_cordic_stage #(
  parameter int DATA_W    = avr_pkg::AVR_COORD_WIDTH + avr_pkg::AVR_GUARD_BITS + 3,
  parameter int COORD_W   = avr_pkg::AVR_COORD_WIDTH,
  parameter int STAGE_IDX = 0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  avr_pkg::avr_ctl_t                         ctl_i,
  input  logic signed [DATA_W-1:0]                  a_i,
  input  logic signed [DATA_W-1:0]                  b_i,
  input  logic signed [avr_pkg::AVR_Z_WIDTH-1:0]    z_i,
  input  logic        [COORD_W-1:0]                 pass_i,
  output avr_pkg::avr_ctl_t                         ctl_o,
  output logic signed [DATA_W-1:0]                  a_o,
  output logic signed [DATA_W-1:0]                  b_o,
  output logic signed [avr_pkg::AVR_Z_WIDTH-1:0]    z_o,
  output logic        [COORD_W-1:0]                 pass_o
);

  localparam logic signed [avr_pkg::AVR_Z_WIDTH-1:0] ATAN_STEP =
    avr_pkg::AVR_Z_WIDTH'(avr_pkg::avr_atan_turn(STAGE_IDX));

  avr_pkg::avr_ctl_t                      ctl_r;
  logic signed [DATA_W-1:0]               a_r, a_nxt;
  logic signed [DATA_W-1:0]               b_r, b_nxt;
  logic signed [avr_pkg::AVR_Z_WIDTH-1:0] z_r, z_nxt;
  logic        [COORD_W-1:0]              pass_r;
  logic signed [DATA_W-1:0]               da, db;

  assign da = b_i >>> STAGE_IDX;
  assign db = a_i >>> STAGE_IDX;

  always_comb begin
    if (ctl_i.mode == avr_pkg::AXIS_NONE) begin
      // no-rotation items ride through untouched
      a_nxt = a_i;
      b_nxt = b_i;
      z_nxt = z_i;
    end else if (!z_i[avr_pkg::AVR_Z_WIDTH-1]) begin
      a_nxt = a_i - da;
      b_nxt = b_i + db;
      z_nxt = z_i - ATAN_STEP;
    end else begin
      a_nxt = a_i + da;
      b_nxt = b_i - db;
      z_nxt = z_i + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      z_r    <= z_nxt;
      pass_r <= pass_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign z_o    = z_r;
  assign pass_o = pass_r;

endmodule

// ===== hdl/avr_gain.sv =====
// gain removal, guard rounding and saturation for the rotated pair
module avr_gain #(
  parameter int DATA_W  = avr_pkg::AVR_COORD_WIDTH + avr_pkg::AVR_GUARD_BITS + 3,
  parameter int COORD_W = avr_pkg::AVR_COORD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  avr_pkg::avr_ctl_t         ctl_i,
  input  logic signed [DATA_W-1:0]  a_i,
  input  logic signed [DATA_W-1:0]  b_i,
  input  logic        [COORD_W-1:0] pass_i,
  output avr_pkg::avr_ctl_t         ctl_o,
  output logic        [COORD_W-1:0] ra_o,
  output logic        [COORD_W-1:0] rb_o,
  output logic        [COORD_W-1:0] pass_o
);

  localparam int GUARD = avr_pkg::AVR_GUARD_BITS;
  localparam int MAG_W = DATA_W - 1;
  localparam int HI_W  = (MAG_W > 32) ? MAG_W - 32 : 1;
  localparam int PH_W  = HI_W + 32;
  localparam int QW    = DATA_W + 1 - GUARD;

  localparam logic signed [QW-1:0] SAT_HI = QW'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);
  localparam logic [DATA_W:0]      HALF_G = (DATA_W + 1)'(1) << (GUARD - 1);
  localparam logic [64:0]          HALF_Q = 65'h0_8000_0000;

  // stage 0: sign and magnitude
  avr_pkg::avr_ctl_t        ctl0_r, ctl1_r, ctl2_r;
  logic        [COORD_W-1:0] pass0_r, pass1_r, pass2_r;
  logic                     neg0_r [2];
  logic        [PH_W-1:0]   mag0_r [2];
  logic                     neg1_r [2];
  logic        [PH_W-1:0]   ph1_r  [2];
  logic        [63:0]       pl1_r  [2];
  logic signed [DATA_W-1:0] v2_r   [2];

  logic signed [DATA_W-1:0] lane_in  [2];
  logic        [PH_W-1:0]   mag_nxt  [2];
  logic        [PH_W-1:0]   ph_nxt   [2];
  logic        [63:0]       pl_nxt   [2];
  logic signed [DATA_W-1:0] v_nxt    [2];
  logic        [COORD_W-1:0] res     [2];

  assign lane_in[0] = a_i;
  assign lane_in[1] = b_i;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic signed [DATA_W-1:0] absv;
      absv       = lane_in[k][DATA_W-1] ? -lane_in[k] : lane_in[k];
      mag_nxt[k] = PH_W'(absv[MAG_W-1:0]);
    end
  end

  // stage 1: q0.32 gain product, split in a low and a high partial product
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (ctl0_r.mode == avr_pkg::AXIS_NONE) begin
        // unity path: the magnitude passes unscaled
        ph_nxt[k] = mag0_r[k];
        pl_nxt[k] = '0;
      end else begin
        ph_nxt[k] = PH_W'(mag0_r[k][PH_W-1:32]) * PH_W'(avr_pkg::AVR_KINV_Q32);
        pl_nxt[k] = 64'(mag0_r[k][31:0]) * 64'(avr_pkg::AVR_KINV_Q32);
      end
    end
  end

  // stage 2: merge partials with half-up rounding, restore sign
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic [64:0]              rnd;
      logic [PH_W-1:0]          p;
      logic signed [DATA_W-1:0] pv;
      rnd      = {1'b0, pl1_r[k]} + HALF_Q;
      p        = ph1_r[k] + PH_W'(rnd[64:32]);
      pv       = DATA_W'(p);
      v_nxt[k] = neg1_r[k] ? -pv : pv;
    end
  end

  // drop guard bits with half-up rounding, then clamp
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic signed [DATA_W:0] sum;
      logic signed [QW-1:0]   q;
      sum = {v2_r[k][DATA_W-1], v2_r[k]} + $signed(HALF_G);
      q   = sum[DATA_W:GUARD];
      if (q > SAT_HI) begin
        res[k] = SAT_HI[COORD_W-1:0];
      end else if (q < SAT_LO) begin
        res[k] = SAT_LO[COORD_W-1:0];
      end else begin
        res[k] = q[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl0_r <= ctl_i;
      ctl1_r <= ctl0_r;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass0_r <= pass_i;
      pass1_r <= pass0_r;
      pass2_r <= pass1_r;
      for (int k = 0; k < 2; k++) begin
        neg0_r[k] <= lane_in[k][DATA_W-1];
        mag0_r[k] <= mag_nxt[k];
        neg1_r[k] <= neg0_r[k];
        ph1_r[k]  <= ph_nxt[k];
        pl1_r[k]  <= pl_nxt[k];
        v2_r[k]   <= v_nxt[k];
      end
    end
  end

  assign ctl_o  = ctl2_r;
  assign pass_o = pass2_r;
  assign ra_o   = res[0];
  assign rb_o   = res[1];

endmodule

// ===== hdl/axis_vector_rotation.sv =====
// top level: pipelined cordic rotation of a 3d vector about one axis
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: vec_x, vec_y, vec_z, turn_angle; in_tuser: mode
//  out_     out  out_tvalid/out_tready out_tdata: rot_x, rot_y, rot_z
//
// one vector per cycle sustained while the skid register is empty; the path from the
// input transfer to out_tvalid is the input register, one register per cordic
// iteration, three gain/rounding registers and the output register
// rst_n is synchronous and clears only the valid and mode bits; no memories, no clearing pass
// the pipeline advances as one while the skid register is empty; a stalled output
// is absorbed by the skid register and in_tready then drops for the stall
`include "axis_vector_rotation_macros.svh"

module axis_vector_rotation #(
  parameter int COORD_WIDTH   = avr_pkg::AVR_COORD_WIDTH,
  parameter int ANGLE_WIDTH   = avr_pkg::AVR_ANGLE_WIDTH,
  parameter int CORDIC_STAGES = avr_pkg::AVR_CORDIC_STAGES,
  localparam int IN_TDATA_W   = ((3 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // vec_x, vec_y, vec_z, turn_angle, zero pad
  input  logic [1:0]             in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // rot_x, rot_y, rot_z, zero pad
);

  localparam int GUARD  = avr_pkg::AVR_GUARD_BITS;
  localparam int ZW     = avr_pkg::AVR_Z_WIDTH;
  // room for the quadrant negation and the cordic gain of about 1.65
  localparam int DATA_W = COORD_WIDTH + GUARD + 3;
  localparam int RES_W  = 3 * COORD_WIDTH;

  // pipeline enable: held off only while the skid register is occupied
  logic en;

  // ---------------------------------------------------------------------------
  // input register: axis decode, quadrant pre-rotation, guard scaling
  // ---------------------------------------------------------------------------
  avr_pkg::avr_axis_t          mode_in;
  avr_pkg::avr_quad_t          quad_in;
  logic [ANGLE_WIDTH-1:0]      ang_in;
  logic signed [DATA_W-1:0]    ext_x, ext_y, ext_z;
  logic signed [DATA_W-1:0]    sel_a, sel_b;
  logic [COORD_WIDTH-1:0]      pass_nxt;

  avr_pkg::avr_ctl_t           ctl0_r;
  logic signed [DATA_W-1:0]    a0_r, a0_nxt;
  logic signed [DATA_W-1:0]    b0_r, b0_nxt;
  logic signed [ZW-1:0]        z0_r, z0_nxt;
  logic [COORD_WIDTH-1:0]      pass0_r;

  assign mode_in = avr_pkg::avr_axis_t'(in_tuser);
  assign ang_in  = in_tdata[3*COORD_WIDTH +: ANGLE_WIDTH];
  assign quad_in = avr_pkg::avr_quad_t'(ang_in[ANGLE_WIDTH-1 -: 2]);

  // sign-extend, then scale by the guard bits
  assign ext_x = DATA_W'($signed(in_tdata[0 +: COORD_WIDTH])) <<< GUARD;
  assign ext_y = DATA_W'($signed(in_tdata[COORD_WIDTH +: COORD_WIDTH])) <<< GUARD;
  assign ext_z = DATA_W'($signed(in_tdata[2*COORD_WIDTH +: COORD_WIDTH])) <<< GUARD;

  // residual angle below a quarter turn, in units of 2^-32 turn
  assign z0_nxt = {2'b00, ang_in[ANGLE_WIDTH-3:0], {(ZW - ANGLE_WIDTH){1'b0}}};

  always_comb begin
    unique case (mode_in) inside
      avr_pkg::AXIS_X: begin
        sel_a    = ext_y;
        sel_b    = ext_z;
        pass_nxt = in_tdata[0 +: COORD_WIDTH];
      end
      avr_pkg::AXIS_Y: begin
        sel_a    = ext_x;
        sel_b    = ext_z;
        pass_nxt = in_tdata[COORD_WIDTH +: COORD_WIDTH];
      end
      avr_pkg::AXIS_Z, avr_pkg::AXIS_NONE: begin
        sel_a    = ext_x;
        sel_b    = ext_y;
        pass_nxt = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
      end
      default: begin
        sel_a    = ext_x;
        sel_b    = ext_y;
        pass_nxt = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
      end
    endcase
  end

  always_comb begin
    a0_nxt = sel_a;
    b0_nxt = sel_b;
    // no-rotation items skip the quadrant step
    if (mode_in != avr_pkg::AXIS_NONE) begin
      unique case (quad_in)
        avr_pkg::QUAD_0: begin
          a0_nxt = sel_a;
          b0_nxt = sel_b;
        end
        avr_pkg::QUAD_1: begin
          a0_nxt = -sel_b;
          b0_nxt = sel_a;
        end
        avr_pkg::QUAD_2: begin
          a0_nxt = -sel_a;
          b0_nxt = -sel_b;
        end
        avr_pkg::QUAD_3: begin
          a0_nxt = sel_b;
          b0_nxt = -sel_a;
        end
        default: begin
          a0_nxt = sel_a;
          b0_nxt = sel_b;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r.vld  <= in_tvalid;
      ctl0_r.mode <= mode_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r    <= a0_nxt;
      b0_r    <= b0_nxt;
      z0_r    <= z0_nxt;
      pass0_r <= pass_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // cordic iterations, one register stage each
  // ---------------------------------------------------------------------------
  avr_pkg::avr_ctl_t        ctl_s  [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] a_s    [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] b_s    [CORDIC_STAGES+1];
  logic signed [ZW-1:0]     z_s    [CORDIC_STAGES+1];
  logic [COORD_WIDTH-1:0]   pass_s [CORDIC_STAGES+1];

  assign ctl_s[0]  = ctl0_r;
  assign a_s[0]    = a0_r;
  assign b_s[0]    = b0_r;
  assign z_s[0]    = z0_r;
  assign pass_s[0] = pass0_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    avr_cordic_stage #(
      .DATA_W    (DATA_W),
      .COORD_W   (COORD_WIDTH),
      .STAGE_IDX (i)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[i]),
      .a_i    (a_s[i]),
      .b_i    (b_s[i]),
      .z_i    (z_s[i]),
      .pass_i (pass_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .a_o    (a_s[i+1]),
      .b_o    (b_s[i+1]),
      .z_o    (z_s[i+1]),
      .pass_o (pass_s[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // gain removal, rounding and saturation (three register stages)
  // ---------------------------------------------------------------------------
  avr_pkg::avr_ctl_t      ctl_g;
  logic [COORD_WIDTH-1:0] ra_g, rb_g, pass_g;

  avr_gain #(
    .DATA_W  (DATA_W),
    .COORD_W (COORD_WIDTH)
  ) u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl_s[CORDIC_STAGES]),
    .a_i    (a_s[CORDIC_STAGES]),
    .b_i    (b_s[CORDIC_STAGES]),
    .pass_i (pass_s[CORDIC_STAGES]),
    .ctl_o  (ctl_g),
    .ra_o   (ra_g),
    .rb_o   (rb_g),
    .pass_o (pass_g)
  );

  // put the rotated pair and the axis component back in x, y, z order
  logic [RES_W-1:0] res_packed;

  always_comb begin
    unique case (ctl_g.mode) inside
      avr_pkg::AXIS_X:                       res_packed = {rb_g, ra_g, pass_g};
      avr_pkg::AXIS_Y:                       res_packed = {rb_g, pass_g, ra_g};
      avr_pkg::AXIS_Z, avr_pkg::AXIS_NONE:   res_packed = {pass_g, rb_g, ra_g};
      default:                               res_packed = {pass_g, rb_g, ra_g};
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register with skid stage
  // ---------------------------------------------------------------------------
  logic             out_valid_r, skid_valid_r;
  logic [RES_W-1:0] out_data_r, skid_data_r;
  logic             push, pop;

  assign en   = !skid_valid_r;
  assign push = en && ctl_g.vld;
  assign pop  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        // drain the skid first; no new transfer can arrive meanwhile
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= res_packed;
      end
    end else if (push) begin
      skid_data_r <= res_packed;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the skid only holds a transfer behind a waiting output
  `AVR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  // a result arriving at a stalled output must land in the skid
  `AVR_ASSERT_NEXT(a_stall_to_skid, out_valid_r && !out_tready && push, skid_valid_r, "result lost")
  // an accepted output drains the skid in the next cycle
  `AVR_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_tready, !skid_valid_r, "skid failed to drain")

endmodule

// ===== tb/axis_vector_rotation_check.sv =====
// result checker for the vector rotation block: predicts each rotated vector and compares
`timescale 1ns / 100ps

module axis_vector_rotation_check
  import avr_pkg::*;
#(
  localparam int CW   = AVR_COORD_WIDTH,
  localparam int IN_W  = ((3 * AVR_COORD_WIDTH + AVR_ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * AVR_COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending_count
);

  localparam int GUARD = AVR_GUARD_BITS;
  localparam longint unsigned GAIN_INV_Q32 = 64'd2608131496;

  // arctangent of 2^-i in units of 2^-32 turn
  longint step_angle [0:23];
  // rotated vectors still in flight, oldest first, packed like out_tdata
  logic [3*CW-1:0] rotated_fifo [$];

  initial begin
    step_angle = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
    fail_count    = 0;
    pending_count = 0;
  end

  // gain correction, rounding back out of the guard bits, saturation
  function automatic logic [CW-1:0] scale_down(input longint v);
    longint unsigned mag, hi, lo, prod;
    longint r;
    longint max_v, min_v;
    max_v = (longint'(1) <<< (CW - 1)) - 1;
    min_v = -max_v - 1;
    mag  = (v < 0) ? -v : v;
    hi   = mag >> 32;
    lo   = mag & 64'hFFFF_FFFF;
    prod = hi * GAIN_INV_Q32 + ((lo * GAIN_INV_Q32 + 64'h8000_0000) >> 32);
    r    = (v < 0) ? -longint'(prod) : longint'(prod);
    r    = (r + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
    if (r > max_v) r = max_v;
    if (r < min_v) r = min_v;
    return r[CW-1:0];
  endfunction

  // cordic rotation of the pair (a, b) by the given turn fraction
  task automatic rotate_pair(input logic [CW-1:0] a_in, input logic [CW-1:0] b_in,
                             input logic [AVR_ANGLE_WIDTH-1:0] ang,
                             output logic [CW-1:0] a_out, output logic [CW-1:0] b_out);
    longint a, b, t, da, db, resid;
    avr_quad_t quad;
    a     = $signed(a_in);
    b     = $signed(b_in);
    a     = a <<< GUARD;
    b     = b <<< GUARD;
    quad  = avr_quad_t'(ang[AVR_ANGLE_WIDTH-1 -: 2]);
    resid = 0;
    resid[31:0] = {2'b00, ang[AVR_ANGLE_WIDTH-3:0], {(32 - AVR_ANGLE_WIDTH){1'b0}}};
    // exact quarter-turn pre-rotation
    case (quad)
      QUAD_1: begin
        t = a; a = -b; b = t;
      end
      QUAD_2: begin
        a = -a; b = -b;
      end
      QUAD_3: begin
        t = a; a = b; b = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < AVR_CORDIC_STAGES && i < 24; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (resid >= 0) begin
        a = a - da; b = b + db; resid = resid - step_angle[i];
      end else begin
        a = a + da; b = b - db; resid = resid + step_angle[i];
      end
    end
    a_out = scale_down(a);
    b_out = scale_down(b);
  endtask

  task automatic predict_rotation(input avr_axis_t axis, input logic [IN_W-1:0] payload,
                                  output logic [3*CW-1:0] rotated);
    logic [CW-1:0] rx, ry, rz;
    logic [AVR_ANGLE_WIDTH-1:0] ang;
    rx  = payload[0 +: CW];
    ry  = payload[CW +: CW];
    rz  = payload[2*CW +: CW];
    ang = payload[3*CW +: AVR_ANGLE_WIDTH];
    case (axis)
      AXIS_X:  rotate_pair(payload[CW +: CW], payload[2*CW +: CW], ang, ry, rz);
      AXIS_Y:  rotate_pair(payload[0 +: CW], payload[2*CW +: CW], ang, rx, rz);
      AXIS_Z:  rotate_pair(payload[0 +: CW], payload[CW +: CW], ang, rx, ry);
      default: ;
    endcase
    rotated = {rz, ry, rx};
  endtask

  always @(posedge clk) begin
    logic [3*CW-1:0] rotated, oldest;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_rotation(avr_axis_t'(in_tuser), in_tdata, rotated);
        rotated_fifo.push_back(rotated);
      end
      if (out_tvalid && out_tready) begin
        if (rotated_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
          fail_count = fail_count + 1;
        end else begin
          oldest = rotated_fifo.pop_front();
          for (int f = 0; f < 3; f++) begin
            if (out_tdata[f*CW +: CW] !== oldest[f*CW +: CW]) begin
              $display("%0t: rot_%s mismatch, expected %h actual %h", $time,
                       (f == 0) ? "x" : (f == 1) ? "y" : "z",
                       oldest[f*CW +: CW], out_tdata[f*CW +: CW]);
              fail_count = fail_count + 1;
            end
          end
        end
      end
      pending_count = rotated_fifo.size();
    end
  end

endmodule

// ===== tb/axis_vector_rotation_test.sv =====
// top of the vector rotation testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module axis_vector_rotation_test;
  import avr_pkg::*;

  localparam int CW    = AVR_COORD_WIDTH;
  localparam int IN_W  = ((3 * AVR_COORD_WIDTH + AVR_ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((3 * AVR_COORD_WIDTH + 7) / 8) * 8;
  // input transfer to out_tvalid, plus margin for the skid register
  localparam int DRAIN_CYCLES = AVR_CORDIC_STAGES + 5 + 20;
  localparam int RANDOM_VECTORS = 1030;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // vec_x, vec_y, vec_z, turn_angle, zero pad
  logic [1:0]       in_tuser = '0;   // mode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // rot_x, rot_y, rot_z, zero pad
  int               fail_count;
  int               pending_count;
  // when set, neither side inserts idle cycles
  logic             steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  axis_vector_rotation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  axis_vector_rotation_check checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // idle length: mostly a few cycles, now and then a long one
  function automatic int idle_cycles();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // coordinate mix: full range, small magnitudes and the extremes
  function automatic logic [CW-1:0] pick_coord();
    logic [CW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [AVR_ANGLE_WIDTH-1:0] pick_angle();
    logic [AVR_ANGLE_WIDTH-1:0] ang;
    ang = $urandom_range(0, (1 << AVR_ANGLE_WIDTH) - 1);
    // land near a quadrant boundary now and then
    if ($urandom_range(0, 7) == 0) ang[AVR_ANGLE_WIDTH-3:0] = $urandom_range(0, 1) ? '0 : '1;
    return ang;
  endfunction

  // one input transfer; in_tvalid stays high unless the sender then idles
  task automatic send_vector(input avr_axis_t axis, input logic [CW-1:0] vx,
                             input logic [CW-1:0] vy, input logic [CW-1:0] vz,
                             input logic [AVR_ANGLE_WIDTH-1:0] ang);
    int gap;
    in_tdata  <= IN_W'({ang, vz, vy, vx});
    in_tuser  <= axis;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = (steady || $urandom_range(0, 1)) ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender off until every rotated vector has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // receiver stalls, with long stretches of steady readiness
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      if (steady || $urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      if (!steady) begin
        out_tready <= 1'b0;
        repeat (idle_cycles()) @(posedge clk);
      end
    end
  end

  initial begin
    avr_axis_t axis;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vector about every axis
    send_vector(AXIS_X, 32'h0, 32'h0, 32'h0, 16'h2000);
    send_vector(AXIS_Y, 32'h0, 32'h0, 32'h0, 16'h6000);
    send_vector(AXIS_Z, 32'h0, 32'h0, 32'h0, 16'hA000);
    // each quadrant about z, unit-scale components
    send_vector(AXIS_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0000);
    send_vector(AXIS_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000);
    send_vector(AXIS_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h8000);
    send_vector(AXIS_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'hC000);
    // quarter turns about x and y, y keeps the same sign form
    send_vector(AXIS_X, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000);
    send_vector(AXIS_Y, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000);
    // smallest and largest nonzero angle
    send_vector(AXIS_Y, 32'hFFFF_0000, 32'h1234_5678, 32'h0040_0000, 16'h0001);
    send_vector(AXIS_X, 32'h1234_5678, 32'hFFFF_0000, 32'h0040_0000, 16'hFFFF);
    // unused axis code passes the vector through
    send_vector(AXIS_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 16'h3000);
    // overflow toward both ends
    send_vector(AXIS_Z, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 16'h2000);
    send_vector(AXIS_Z, 32'h8000_0000, 32'h8000_0000, 32'h0, 16'h2000);
    send_vector(AXIS_X, 32'h0, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    send_vector(AXIS_Y, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 16'hE000);
    // all ones and alternating bit patterns
    send_vector(AXIS_Z, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_vector(AXIS_X, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    send_vector(AXIS_Y, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);

    drain_results();

    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      if (n % 100 == 0) steady <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_VECTORS / 2) drain_results();
      axis = ($urandom_range(0, 15) == 0) ? AXIS_NONE : avr_axis_t'($urandom_range(0, 2));
      send_vector(axis, pick_coord(), pick_coord(), pick_coord(), pick_angle());
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // generous bound on the whole run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
